// File: design/rfd_pkg.sv
// Shared constants, types and helper functions for the remote frame decoder.
package rfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int FRAME_W     = 8 * FRAME_BYTES;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int STORE_DEPTH = FRAME_BYTES - 1;

    localparam int CH_W        = 11;
    localparam int LIMIT_W     = 10;
    localparam int AXIS_W      = 16;
    localparam int BTN_W       = 20;
    localparam int KEY_W       = 16;
    localparam int NUM_MODES   = 3;
    localparam int EDGE_W      = KEY_W * NUM_MODES;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 16;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam int SHIFT_BIT   = 6;
    localparam int CTRL_BIT    = 7;
    localparam logic [KEY_W-1:0] MOD_MASK = 16'h00C0;

    localparam logic [CH_W-1:0]    OFFSET_RESET = 11'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd660;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STICK_LIMIT    = 1'd1;

    // Input command codes
    localparam logic [1:0] CMD_BYTE      = 2'd0;
    localparam logic [1:0] CMD_LINK_LOST = 2'd1;
    localparam logic [1:0] CMD_READ      = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    // Work handed from the byte collector to the decode stage
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] counter_index;
        logic [FRAME_W-1:0] frame;
    } job_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] op;
    } key_ctl_t;

    // Wire order W S A D Shift Ctrl Q E -> W S A D Q E Shift Ctrl
    function automatic logic [KEY_W-1:0] remap_keys(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] m;
        m        = raw;
        m[4]     = raw[6];
        m[5]     = raw[7];
        m[6]     = raw[4];
        m[7]     = raw[5];
        return m;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [FRAME_W-1:0] f, input int i);
        return f[8*i +: 8];
    endfunction

endpackage

// File: design/rfd_stick.sv
// One stick channel: subtract the center offset, zero it beyond the limit.
module rfd_stick (
    input  logic [rfd_pkg::CH_W-1:0]    raw,
    input  logic [rfd_pkg::CH_W-1:0]    offset,
    input  logic [rfd_pkg::LIMIT_W-1:0] limit,
    output logic signed [rfd_pkg::CH_W-1:0] value
);
    import rfd_pkg::*;

    logic signed [CH_W:0] diff;
    logic        [CH_W:0] mag;

    always_comb
    begin
        diff = $signed({1'b0, raw}) - $signed({1'b0, offset});
        mag  = diff[CH_W] ? (~diff + 1'b1) : diff;
        if (mag > {{(CH_W + 1 - LIMIT_W){1'b0}}, limit})
        begin
            value = '0;
        end
        else
        begin
            value = diff[CH_W-1:0];
        end
    end

endmodule

// File: design/rfd_collect.sv
// Byte collector: assembles frames and registers one job per frame, link loss or read.
module rfd_collect (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               command,
    input  logic [7:0]               rx_byte,
    input  logic [rfd_pkg::IDX_W-1:0] counter_index,
    output logic                     job_valid,
    output rfd_pkg::job_t            job,
    input  logic                     job_take
);
    import rfd_pkg::*;

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [7:0]       store_reg [STORE_DEPTH];
    logic             job_valid_reg;
    job_t             job_reg, job_next;
    logic             accept;
    logic             has_job;
    logic [POS_W-1:0] pos_eff;
    logic             last_byte;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = job_valid_reg && !job_take;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        pos_eff   = (byte_position_reg >= POS_W'(FRAME_BYTES)) ? '0 : byte_position_reg;
        last_byte = (pos_eff == POS_W'(FRAME_BYTES - 1));
        byte_position_next = byte_position_reg;
        has_job   = 1'b0;
        job_next.op            = OP_FRAME;
        job_next.counter_index = counter_index;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            job_next.frame[8*i +: 8] = store_reg[i];
        end
        job_next.frame[8*STORE_DEPTH +: 8] = rx_byte;
        unique case (command)
            CMD_BYTE:
            begin
                has_job            = last_byte;
                byte_position_next = last_byte ? '0 : pos_eff + 1'b1;
            end
            CMD_LINK_LOST:
            begin
                has_job            = 1'b1;
                job_next.op        = OP_CLEAR;
                byte_position_next = '0;
            end
            CMD_READ:
            begin
                has_job     = 1'b1;
                job_next.op = OP_READ;
            end
            CMD_UNUSED:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            job_valid_reg     <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            job_valid_reg     <= has_job;
        end
        else if (job_take)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    // Frame bytes and job payload carry no reset
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_BYTE && !last_byte)
        begin
            store_reg[pos_eff] <= rx_byte;
        end
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg < POS_W'(FRAME_BYTES))
        else $error("byte position out of range");

endmodule

// File: design/rfd_keys.sv
// Key tracking: remapped mask, rising edges per mode and an edge counter per key and mode.
module rfd_keys (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rfd_pkg::key_ctl_t         ctl,
    input  logic [rfd_pkg::KEY_W-1:0] raw_keys,
    input  logic [rfd_pkg::IDX_W-1:0] read_index,
    output logic [rfd_pkg::KEY_W-1:0] remapped_keys,
    output logic [rfd_pkg::EDGE_W-1:0] key_edges,
    output logic [rfd_pkg::CNT_W-1:0] counter_value
);
    import rfd_pkg::*;

    logic [KEY_W-1:0] last_plain_reg, last_ctrl_reg, last_shift_reg;
    logic [CNT_W-1:0] cnt_reg [NUM_MODES][KEY_W];
    logic [KEY_W-1:0] now, with_ctrl, with_shift;
    logic [KEY_W-1:0] e_plain, e_ctrl, e_shift;
    logic [1:0]       rd_mode;
    logic [3:0]       rd_key;
    logic             do_frame, do_clear;

    assign do_frame = ctl.fire && (ctl.op == OP_FRAME);
    assign do_clear = ctl.fire && (ctl.op == OP_CLEAR);

    always_comb
    begin
        now        = remap_keys(raw_keys);
        with_ctrl  = now[CTRL_BIT]  ? now : '0;
        with_shift = now[SHIFT_BIT] ? now : '0;
        e_plain    = now & ~last_plain_reg & ~with_ctrl & ~with_shift & ~MOD_MASK;
        e_ctrl     = with_ctrl & ~last_ctrl_reg & ~MOD_MASK;
        e_shift    = with_shift & ~last_shift_reg & ~MOD_MASK;
    end

    assign remapped_keys = now;
    assign key_edges     = {e_shift, e_ctrl, e_plain};

    always_comb
    begin
        rd_mode = read_index[IDX_W-1:4];
        rd_key  = read_index[3:0];
        if (rd_mode < 2'(NUM_MODES))
        begin
            counter_value = cnt_reg[rd_mode][rd_key];
        end
        else
        begin
            counter_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_plain_reg <= '0;
            last_ctrl_reg  <= '0;
            last_shift_reg <= '0;
            for (int m = 0; m < NUM_MODES; m++)
            begin
                for (int k = 0; k < KEY_W; k++)
                begin
                    cnt_reg[m][k] <= '0;
                end
            end
        end
        else if (do_clear)
        begin
            last_plain_reg <= '0;
            last_ctrl_reg  <= '0;
            last_shift_reg <= '0;
            for (int m = 0; m < NUM_MODES; m++)
            begin
                for (int k = 0; k < KEY_W; k++)
                begin
                    cnt_reg[m][k] <= '0;
                end
            end
        end
        else if (do_frame)
        begin
            last_plain_reg <= now;
            last_ctrl_reg  <= with_ctrl;
            last_shift_reg <= with_shift;
            // each counter is its own incrementer; several may bump together
            for (int m = 0; m < NUM_MODES; m++)
            begin
                for (int k = 0; k < KEY_W; k++)
                begin
                    if (key_edges[m*KEY_W + k])
                    begin
                        cnt_reg[m][k] <= cnt_reg[m][k] + 1'b1;
                    end
                end
            end
        end
    end

    a_no_mod_edges: assert property (@(posedge clk) disable iff (!rst_n)
        (key_edges & {MOD_MASK, MOD_MASK, MOD_MASK}) == '0)
        else $error("modifier bit reported as edge");

    a_clear_keys: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (last_plain_reg == '0 && last_ctrl_reg == '0 && last_shift_reg == '0
                      && cnt_reg[0][0] == '0))
        else $error("link lost did not clear key state");

endmodule

// File: design/remote_frame_decoder_keyedge_core.sv
// Top level of the remote frame decoder: collector, decode stage and result register.
//
//  channel | direction | handshake          | payload
//  in      | to core   | in_valid/in_stall  | command, rx_byte, counter_index
//  out     | from core | out_valid/out_stall| sticks, mouse, buttons, keys, edges, counter
//  cfg     | to core   | cfg_we             | cfg_index, cfg_data
//
// An item is registered by the collector, decoded and written to the result register
// when that register is free; one transfer per cycle sustained while out_stall is low.
// The decode stage (stick rectify, key edges, 48 parallel counter increments)
// is the single combinational step between the job and result registers.
// Reset clears byte position, key history, counters and valid flags; config
// returns to offset 1024 and limit 660. A stalled result holds the job register
// and raises in_stall once that register is also occupied.
module remote_frame_decoder_keyedge_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [7:0]                     rx_byte,
    input  logic [rfd_pkg::IDX_W-1:0]      counter_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [rfd_pkg::CH_W-1:0]   right_stick_x,
    output logic signed [rfd_pkg::CH_W-1:0]   right_stick_y,
    output logic signed [rfd_pkg::CH_W-1:0]   left_stick_x,
    output logic signed [rfd_pkg::CH_W-1:0]   left_stick_y,
    output logic signed [rfd_pkg::AXIS_W-1:0] mouse_x,
    output logic signed [rfd_pkg::AXIS_W-1:0] mouse_y,
    output logic signed [rfd_pkg::AXIS_W-1:0] mouse_z,
    output logic [rfd_pkg::BTN_W-1:0]      buttons_and_switches,
    output logic [rfd_pkg::KEY_W-1:0]      remapped_keys,
    output logic [rfd_pkg::KEY_W-1:0]      trailer_raw,
    output logic [rfd_pkg::EDGE_W-1:0]     key_edges,
    output logic [rfd_pkg::CNT_W-1:0]      counter_value
);
    import rfd_pkg::*;

    logic [CH_W-1:0]    offset_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic     job_valid;
    job_t     job;
    logic     job_take;
    key_ctl_t key_ctl;

    logic [7:0] b [FRAME_BYTES];
    logic [CH_W-1:0] ch [4];
    logic signed [CH_W-1:0] stick [4];
    logic [KEY_W-1:0]  now_mask;
    logic [EDGE_W-1:0] edges;
    logic [CNT_W-1:0]  cnt_value;

    logic out_valid_reg;
    logic signed [CH_W-1:0]   rsx_reg, rsy_reg, lsx_reg, lsy_reg;
    logic signed [AXIS_W-1:0] mx_reg, my_reg, mz_reg;
    logic [BTN_W-1:0]  btn_reg;
    logic [KEY_W-1:0]  mask_reg, trailer_reg;
    logic [EDGE_W-1:0] edges_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_OFFSET: offset_reg <= cfg_data[CH_W-1:0];
                REG_STICK_LIMIT:    limit_reg  <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    rfd_collect u_collect (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .rx_byte       (rx_byte),
        .counter_index (counter_index),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take)
    );

    assign job_take     = job_valid && (!out_valid_reg || !out_stall);
    assign key_ctl.fire = job_take;
    assign key_ctl.op   = job.op;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            b[i] = frame_byte(job.frame, i);
        end
        ch[0] = {b[1][2:0], b[0]};
        ch[1] = {b[2][5:0], b[1][7:3]};
        ch[2] = {b[4][0], b[3], b[2][7:6]};
        ch[3] = {b[5][3:0], b[4][7:1]};
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_stick
        rfd_stick u_stick (
            .raw    (ch[g]),
            .offset (offset_reg),
            .limit  (limit_reg),
            .value  (stick[g])
        );
    end

    rfd_keys u_keys (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (key_ctl),
        .raw_keys      ({b[15], b[14]}),
        .read_index    (job.counter_index),
        .remapped_keys (now_mask),
        .key_edges     (edges),
        .counter_value (cnt_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (job_take)
        begin
            out_valid_reg <= (job.op != OP_CLEAR);
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            if (job.op == OP_READ)
            begin
                rsx_reg     <= '0;
                rsy_reg     <= '0;
                lsx_reg     <= '0;
                lsy_reg     <= '0;
                mx_reg      <= '0;
                my_reg      <= '0;
                mz_reg      <= '0;
                btn_reg     <= '0;
                mask_reg    <= '0;
                trailer_reg <= '0;
                edges_reg   <= '0;
                cnt_reg     <= cnt_value;
            end
            else
            begin
                rsx_reg     <= stick[0];
                rsy_reg     <= stick[1];
                lsx_reg     <= stick[2];
                lsy_reg     <= stick[3];
                mx_reg      <= {b[7], b[6]};
                my_reg      <= {b[9], b[8]};
                mz_reg      <= {b[11], b[10]};
                btn_reg     <= {b[5][7:6], b[5][5:4], b[13], b[12]};
                mask_reg    <= now_mask;
                trailer_reg <= {b[17], b[16]};
                edges_reg   <= edges;
                cnt_reg     <= '0;
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign right_stick_x        = rsx_reg;
    assign right_stick_y        = rsy_reg;
    assign left_stick_x         = lsx_reg;
    assign left_stick_y         = lsy_reg;
    assign mouse_x              = mx_reg;
    assign mouse_y              = my_reg;
    assign mouse_z              = mz_reg;
    assign buttons_and_switches = btn_reg;
    assign remapped_keys        = mask_reg;
    assign trailer_raw          = trailer_reg;
    assign key_edges            = edges_reg;
    assign counter_value        = cnt_reg;

    a_read_only_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cnt_reg != '0) |-> (edges_reg == '0 && mask_reg == '0))
        else $error("read result carries frame fields");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the remote frame decoder: frame, clear and counter-read traffic.
module tb;
    import rfd_pkg::*;

    localparam int PHASE_LOAD = 305;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [1:0]       cmd;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } rc_input_t;

    typedef struct packed {
        logic [CH_W-1:0]   rs_x;
        logic [CH_W-1:0]   rs_y;
        logic [CH_W-1:0]   ls_x;
        logic [CH_W-1:0]   ls_y;
        logic [AXIS_W-1:0] mouse_x;
        logic [AXIS_W-1:0] mouse_y;
        logic [AXIS_W-1:0] mouse_z;
        logic [BTN_W-1:0]  buttons;
        logic [KEY_W-1:0]  keys;
        logic [KEY_W-1:0]  trailer;
        logic [EDGE_W-1:0] edges;
        logic [CNT_W-1:0]  count;
    } rc_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = CMD_BYTE;
    logic [7:0] rx_byte = '0;
    logic [IDX_W-1:0] counter_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [CH_W-1:0] right_stick_x;
    logic signed [CH_W-1:0] right_stick_y;
    logic signed [CH_W-1:0] left_stick_x;
    logic signed [CH_W-1:0] left_stick_y;
    logic signed [AXIS_W-1:0] mouse_x;
    logic signed [AXIS_W-1:0] mouse_y;
    logic signed [AXIS_W-1:0] mouse_z;
    logic [BTN_W-1:0] buttons_and_switches;
    logic [KEY_W-1:0] remapped_keys;
    logic [KEY_W-1:0] trailer_raw;
    logic [EDGE_W-1:0] key_edges;
    logic [CNT_W-1:0] counter_value;

    remote_frame_decoder_keyedge_core dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .command              (command),
        .rx_byte              (rx_byte),
        .counter_index        (counter_index),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .right_stick_x        (right_stick_x),
        .right_stick_y        (right_stick_y),
        .left_stick_x         (left_stick_x),
        .left_stick_y         (left_stick_y),
        .mouse_x              (mouse_x),
        .mouse_y              (mouse_y),
        .mouse_z              (mouse_z),
        .buttons_and_switches (buttons_and_switches),
        .remapped_keys        (remapped_keys),
        .trailer_raw          (trailer_raw),
        .key_edges            (key_edges),
        .counter_value        (counter_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("timeout: decoder stopped making progress");
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus side
    rc_input_t pending_items[$];
    int n_queued = 0;
    int n_taken = 0;
    int n_offered = 0;
    int phase_load = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic [KEY_W-1:0] gen_keys = '0;

    // decoder shadow state
    logic [CH_W-1:0] chan_offset = OFFSET_RESET;
    logic [LIMIT_W-1:0] stick_lim = LIMIT_RESET;
    int byte_pos = 0;
    logic [7:0] rx_frame[FRAME_BYTES];
    logic [KEY_W-1:0] prev_plain = '0;
    logic [KEY_W-1:0] prev_ctrl = '0;
    logic [KEY_W-1:0] prev_shift = '0;
    logic [CNT_W-1:0] key_tally[NUM_MODES*KEY_W];

    rc_report_t expected_reports[$];
    int mismatches = 0;
    int n_frames = 0;
    int n_reads = 0;
    int n_clears = 0;

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [IDX_W-1:0] idx);
        rc_input_t it;
        it.cmd = cmd;
        it.data = data;
        it.idx = idx;
        pending_items.push_back(it);
        n_queued++;
        if (cmd != CMD_UNUSED)
            phase_load++;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(7) == 0)
            return IDX_W'($urandom_range(63, NUM_MODES*KEY_W));
        return IDX_W'($urandom_range(NUM_MODES*KEY_W - 1));
    endfunction

    // Bytes of one frame, cut short after 'cut' bytes; reads and unused
    // commands may be slipped in between bytes.
    task automatic queue_frame(input logic [10:0] c0, input logic [10:0] c1,
                               input logic [10:0] c2, input logic [10:0] c3,
                               input logic [3:0] sw, input logic [15:0] mx,
                               input logic [15:0] my, input logic [15:0] mz,
                               input logic [7:0] bl, input logic [7:0] br,
                               input logic [15:0] keys, input logic [15:0] trailer,
                               input int cut, input bit mix);
        logic [FRAME_W-1:0] fr;
        fr = {trailer, keys, br, bl, mz, my, mx, sw, c3, c2, c1, c0};
        for (int i = 0; i < cut; i++)
        begin
            push_item(CMD_BYTE, fr[8*i +: 8], IDX_W'($urandom));
            if (mix && $urandom_range(99) < 4)
            begin
                if ($urandom_range(9) < 7)
                    push_item(CMD_READ, 8'($urandom), pick_index());
                else
                    push_item(CMD_UNUSED, 8'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    // Raw channel value aimed around the current center and limit.
    function automatic logic [10:0] pick_stick();
        int lim;
        int mag;
        int d;
        int sel;
        lim = int'(stick_lim);
        d = 0;
        case ($urandom_range(3))
            0: return 11'($urandom);
            1: d = int'($urandom_range(2*lim)) - lim;
            2:
            begin
                mag = lim + int'($urandom_range(1));
                d = $urandom_range(1) ? mag : -mag;
            end
            default:
            begin
                sel = $urandom_range(2);
                return (sel == 0) ? 11'h000 : (sel == 1) ? 11'h7ff : chan_offset;
            end
        endcase
        return 11'(int'(chan_offset) + d);
    endfunction

    task automatic queue_random_frame(input int cut);
        logic [15:0] keys;
        case ($urandom_range(4))
            0: keys = 16'($urandom);
            1: keys = gen_keys;
            2: keys = gen_keys ^ (16'h0001 << $urandom_range(15));
            3: keys = '0;
            default: keys = gen_keys ^ (16'h0030 & 16'($urandom));
        endcase
        gen_keys = keys;
        queue_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                    4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom), 8'($urandom), keys, 16'($urandom), cut, 1'b1);
    endtask

    task automatic load_directed();
        push_item(CMD_READ, 8'h00, 6'd0);
        push_item(CMD_READ, 8'hff, 6'd63);
        push_item(CMD_UNUSED, 8'hff, 6'd63);
        // partial frame dropped by a link loss
        queue_frame(11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 4'hf, 16'hffff, 16'hffff,
                    16'hffff, 8'hff, 8'hff, 16'hffff, 16'hffff, 3, 1'b0);
        push_item(CMD_LINK_LOST, 8'h00, 6'd0);
        // sticks at +limit, -(limit+1), -limit, top; both modifiers held
        queue_frame(11'd1684, 11'd363, 11'd364, 11'd2047, 4'b1001, 16'h8000, 16'h7fff,
                    16'hffff, 8'h00, 8'hff, 16'hffff, 16'h0000, FRAME_BYTES, 1'b0);
        push_item(CMD_READ, 8'h00, 6'd16);
        push_item(CMD_READ, 8'h00, 6'd47);
    endtask

    task automatic load_random(input int target);
        int roll;
        phase_load = 0;
        while (phase_load < target)
        begin
            roll = $urandom_range(99);
            if (roll < 72)
                queue_random_frame(FRAME_BYTES);
            else if (roll < 86)
                push_item(CMD_READ, 8'($urandom), pick_index());
            else if (roll < 90)
                push_item(CMD_LINK_LOST, 8'($urandom), IDX_W'($urandom));
            else if (roll < 96)
            begin
                queue_random_frame($urandom_range(FRAME_BYTES - 1, 1));
                push_item(CMD_LINK_LOST, 8'($urandom), IDX_W'($urandom));
            end
            else
                push_item(CMD_UNUSED, 8'($urandom), IDX_W'($urandom));
        end
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] offset_val,
                                input logic [CFG_DATA_W-1:0] limit_val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_CHANNEL_OFFSET;
        cfg_data <= offset_val;
        @(negedge clk);
        cfg_index <= REG_STICK_LIMIT;
        cfg_data <= limit_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        chan_offset = offset_val;
        stick_lim = limit_val[LIMIT_W-1:0];
    endtask

    task automatic drain();
        while (n_taken != n_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] center_stick(input logic [10:0] raw);
        int v;
        int mag;
        v = int'(raw) - int'(chan_offset);
        mag = (v < 0) ? -v : v;
        if (mag > int'(stick_lim))
            v = 0;
        return v[CH_W-1:0];
    endfunction

    function automatic void clear_decoder();
        byte_pos = 0;
        prev_plain = '0;
        prev_ctrl = '0;
        prev_shift = '0;
        foreach (key_tally[i])
            key_tally[i] = '0;
    endfunction

    function automatic rc_report_t decode_frame();
        rc_report_t rep;
        logic [47:0] lo;
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] now;
        logic [KEY_W-1:0] with_ctrl;
        logic [KEY_W-1:0] with_shift;
        logic [KEY_W-1:0] e_plain;
        logic [KEY_W-1:0] e_ctrl;
        logic [KEY_W-1:0] e_shift;
        rep = '0;
        lo = {rx_frame[5], rx_frame[4], rx_frame[3], rx_frame[2], rx_frame[1], rx_frame[0]};
        rep.rs_x = center_stick(lo[10:0]);
        rep.rs_y = center_stick(lo[21:11]);
        rep.ls_x = center_stick(lo[32:22]);
        rep.ls_y = center_stick(lo[43:33]);
        rep.mouse_x = {rx_frame[7], rx_frame[6]};
        rep.mouse_y = {rx_frame[9], rx_frame[8]};
        rep.mouse_z = {rx_frame[11], rx_frame[10]};
        rep.buttons = {lo[47:44], rx_frame[13], rx_frame[12]};
        raw = {rx_frame[15], rx_frame[14]};
        // wire order has Shift, Ctrl ahead of Q, E
        now = {raw[15:8], raw[5], raw[4], raw[7], raw[6], raw[3:0]};
        with_ctrl = now[CTRL_BIT] ? now : '0;
        with_shift = now[SHIFT_BIT] ? now : '0;
        e_plain = now & ~prev_plain & ~with_ctrl & ~with_shift & ~MOD_MASK;
        e_ctrl = with_ctrl & ~prev_ctrl & ~MOD_MASK;
        e_shift = with_shift & ~prev_shift & ~MOD_MASK;
        for (int i = 0; i < KEY_W; i++)
        begin
            if (e_plain[i])
                key_tally[i] = key_tally[i] + 1'b1;
            if (e_ctrl[i])
                key_tally[KEY_W + i] = key_tally[KEY_W + i] + 1'b1;
            if (e_shift[i])
                key_tally[2*KEY_W + i] = key_tally[2*KEY_W + i] + 1'b1;
        end
        prev_plain = now;
        prev_ctrl = with_ctrl;
        prev_shift = with_shift;
        rep.keys = now;
        rep.trailer = {rx_frame[17], rx_frame[16]};
        rep.edges = {e_shift, e_ctrl, e_plain};
        return rep;
    endfunction

    function automatic void absorb_input(input logic [1:0] cmd, input logic [7:0] data,
                                         input logic [IDX_W-1:0] idx);
        rc_report_t rep;
        rep = '0;
        case (cmd)
            CMD_BYTE:
            begin
                rx_frame[byte_pos] = data;
                if (byte_pos == FRAME_BYTES - 1)
                begin
                    byte_pos = 0;
                    expected_reports.push_back(decode_frame());
                    n_frames++;
                end
                else
                    byte_pos++;
            end
            CMD_LINK_LOST:
            begin
                clear_decoder();
                n_clears++;
            end
            CMD_READ:
            begin
                if (idx < NUM_MODES*KEY_W)
                    rep.count = key_tally[idx];
                expected_reports.push_back(rep);
                n_reads++;
            end
            default: ;
        endcase
    endfunction

    // driver: a new transfer is offered only once the previous one went through
    always @(negedge clk)
    begin : drive_inputs
        rc_input_t nxt;
        if (rst_n && n_taken == n_offered)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                command <= nxt.cmd;
                rx_byte <= nxt.data;
                counter_index <= nxt.idx;
                n_offered++;
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            absorb_input(command, rx_byte, counter_index);
            n_taken++;
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : watch_results
        rc_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result transfer with nothing pending", $realtime);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("right_stick_x", want.rs_x, $unsigned(right_stick_x));
                check_field("right_stick_y", want.rs_y, $unsigned(right_stick_y));
                check_field("left_stick_x", want.ls_x, $unsigned(left_stick_x));
                check_field("left_stick_y", want.ls_y, $unsigned(left_stick_y));
                check_field("mouse_x", want.mouse_x, $unsigned(mouse_x));
                check_field("mouse_y", want.mouse_y, $unsigned(mouse_y));
                check_field("mouse_z", want.mouse_z, $unsigned(mouse_z));
                check_field("buttons_and_switches", want.buttons, buttons_and_switches);
                check_field("remapped_keys", want.keys, remapped_keys);
                check_field("trailer_raw", want.trailer, trailer_raw);
                check_field("key_edges", want.edges, key_edges);
                check_field("counter_value", want.count, counter_value);
            end
        end
    end

    initial
    begin : run
        foreach (key_tally[i])
            key_tally[i] = '0;
        send_idle_pct = 10;
        recv_idle_pct = 78;
        load_directed();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 10;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: program_regs(11'd0, 11'd0);
                1: program_regs(11'd2047, 11'd1023);
                3: program_regs(11'd1024, 11'd660);
                5: program_regs(11'd0, 11'd1023);
                default: program_regs(11'($urandom), 11'($urandom));
            endcase
            load_random(PHASE_LOAD);
            drain();
        end
        $display("Covered %0d input transfers: %0d frames, %0d counter reads, %0d link losses",
                 n_taken, n_frames, n_reads, n_clears);
        $display("Six register settings plus reset values; %0d mismatches, %0d results missing",
                 mismatches, expected_reports.size());
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
